>>> design/gzhp_pkg.sv
// ----------------------------------------------------------------------------
// gzhp_pkg
// Shared types, codes and helpers for the gzip member header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

  // width of the internal header byte counter, saturating
  localparam int COUNT_BITS = 24;
  // width of the reported header length
  localparam int HDR_LEN_W = 24;
  // width used to compare the counter against the report limit
  localparam int CMP_W = (COUNT_BITS > HDR_LEN_W) ? COUNT_BITS : HDR_LEN_W;

  // fixed part: magic (2), method, flags, mtime (4), xfl, os
  localparam logic [3:0] FIXED_LAST = 4'(2 + 1 + 1 + 6 - 1);

  localparam logic [7:0] MAGIC_0 = 8'h1f;
  localparam logic [7:0] MAGIC_1 = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'h08;
  localparam logic [7:0] FLAG_MASK = 8'h1f;

  localparam logic [4:0] FLG_HCRC = 5'h02;
  localparam logic [4:0] FLG_EXTRA = 5'h04;
  localparam logic [4:0] FLG_NAME = 5'h08;
  localparam logic [4:0] FLG_COMMENT = 5'h10;

  localparam logic [15:0] CRC_LEN = 16'd2;

  // per-item status codes
  localparam logic [1:0] ST_HEADER = 2'd0;
  localparam logic [1:0] ST_LAST = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;
  localparam logic [1:0] ST_PAYLOAD = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_MAGIC = 3'd1;
  localparam logic [2:0] ERR_METHOD = 3'd2;
  localparam logic [2:0] ERR_FLAGS = 3'd3;
  localparam logic [2:0] ERR_TRUNC = 3'd4;

  typedef enum logic [3:0] {
    PH_FIXED = 4'd0,
    PH_XLO = 4'd1,
    PH_XHI = 4'd2,
    PH_EXTRA = 4'd3,
    PH_NAME = 4'd4,
    PH_COMMENT = 4'd5,
    PH_CRC = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_ERROR = 4'd8
  } phase_t;

  // next optional section after the given one, payload when none is left
  function automatic phase_t section_after(input phase_t stage, input logic [4:0] flags);
    phase_t res;
    if (stage < PH_XLO && (flags & FLG_EXTRA) != 5'd0) begin
      res = PH_XLO;
    end else if (stage < PH_NAME && (flags & FLG_NAME) != 5'd0) begin
      res = PH_NAME;
    end else if (stage < PH_COMMENT && (flags & FLG_COMMENT) != 5'd0) begin
      res = PH_COMMENT;
    end else if (stage < PH_CRC && (flags & FLG_HCRC) != 5'd0) begin
      res = PH_CRC;
    end else begin
      res = PH_PAYLOAD;
    end
    return res;
  endfunction

endpackage

>>> design/gzip_header_parser.sv
// ----------------------------------------------------------------------------
// gzip_header_parser
// Walks the header of a gzip member one byte per item and classes each byte
// as header, last header byte, error or payload.
// ----------------------------------------------------------------------------
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+----
//  in      | in_valid, in_stall, data_byte, first, stream_end | in
//  out     | out_valid, out_stall, status, error_code,        | out
//          | header_length, payload_byte                      |
//
// One item per cycle while in_stall is low: the parse state and the result
// register both update at the accepting edge, and the result shows in the next cycle.
// Throughput is set by the single output register: in_stall is high only
// while a result is held and stalled downstream.
// Reset (rst, synchronous) clears the parse to the first fixed header byte
// and empties the output register.
module gzip_header_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              first,
  input  logic                              stream_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [2:0]                        error_code,
  output logic [gzhp_pkg::HDR_LEN_W-1:0]    header_length,
  output logic [7:0]                        payload_byte
);
  import gzhp_pkg::*;

  // parse state
  phase_t                phase, phase_next;
  logic [3:0]            fixed_index, fixed_index_next;
  logic [4:0]            flag_bits, flag_bits_next;
  logic [15:0]           skip_count, skip_count_next;
  logic [7:0]            length_low, length_low_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [2:0]            error_latched, error_latched_next;

  // state seen by this item, after an optional restart
  phase_t                cur_phase;
  logic [3:0]            cur_index;
  logic [4:0]            cur_flags;
  logic [15:0]           cur_skip;
  logic [7:0]            cur_low;
  logic [COUNT_BITS-1:0] cur_count;
  logic [2:0]            cur_err;

  logic [2:0]            chk_err;
  logic [15:0]           skip_dec;
  logic [15:0]           xlen;
  logic [CMP_W-1:0]      count_wide;
  logic [1:0]            status_next;
  logic [2:0]            code_next;
  logic [HDR_LEN_W-1:0]  length_next;
  logic [7:0]            pay_next;
  logic                  accept;

  assign in_stall = out_valid & out_stall;
  assign accept = in_valid & ~in_stall;

  // restart mux
  always_comb begin
    if (first) begin
      cur_phase = PH_FIXED;
      cur_index = 4'd0;
      cur_flags = 5'd0;
      cur_skip = 16'd0;
      cur_low = 8'd0;
      cur_count = '0;
      cur_err = ERR_NONE;
    end else begin
      cur_phase = phase;
      cur_index = fixed_index;
      cur_flags = flag_bits;
      cur_skip = skip_count;
      cur_low = length_low;
      cur_count = byte_count;
      cur_err = error_latched;
    end
  end

  // header checks on the fixed part
  always_comb begin
    chk_err = ERR_NONE;
    if (cur_index == 4'd0 && data_byte != MAGIC_0) begin
      chk_err = ERR_MAGIC;
    end else if (cur_index == 4'd1 && data_byte != MAGIC_1) begin
      chk_err = ERR_MAGIC;
    end else if (cur_index == 4'd2 && data_byte != METHOD_DEFLATE) begin
      chk_err = ERR_METHOD;
    end else if (cur_index == 4'd3 && (data_byte & ~FLAG_MASK) != 8'd0) begin
      chk_err = ERR_FLAGS;
    end
  end

  assign skip_dec = cur_skip - 16'd1;
  assign xlen = {data_byte, cur_low};

  // next state and result
  always_comb begin
    phase_next = cur_phase;
    fixed_index_next = cur_index;
    flag_bits_next = cur_flags;
    skip_count_next = cur_skip;
    length_low_next = cur_low;
    byte_count_next = cur_count;
    error_latched_next = cur_err;
    status_next = ST_HEADER;
    code_next = ERR_NONE;
    pay_next = 8'd0;

    if (cur_phase == PH_PAYLOAD) begin
      status_next = ST_PAYLOAD;
      pay_next = data_byte;
    end else if (cur_phase == PH_ERROR) begin
      status_next = ST_ERROR;
      code_next = cur_err;
    end else if (cur_phase == PH_FIXED && chk_err != ERR_NONE) begin
      // rejected byte is not counted
      error_latched_next = chk_err;
      phase_next = PH_ERROR;
      status_next = ST_ERROR;
      code_next = chk_err;
    end else begin
      case (cur_phase)
        PH_FIXED: begin
          if (cur_index == 4'd3) begin
            flag_bits_next = data_byte[4:0];
          end
          if (cur_index >= FIXED_LAST) begin
            phase_next = section_after(PH_FIXED, flag_bits_next);
          end else begin
            fixed_index_next = cur_index + 4'd1;
          end
        end
        PH_XLO: begin
          length_low_next = data_byte;
          phase_next = PH_XHI;
        end
        PH_XHI: begin
          skip_count_next = xlen;
          if (xlen != 16'd0) begin
            phase_next = PH_EXTRA;
          end else begin
            phase_next = section_after(PH_EXTRA, cur_flags);
          end
        end
        PH_EXTRA, PH_CRC: begin
          skip_count_next = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_next = section_after(cur_phase, cur_flags);
          end
        end
        default: begin
          // name or comment: zero terminated
          if (data_byte == 8'd0) begin
            phase_next = section_after(cur_phase, cur_flags);
          end
        end
      endcase

      // entering the header crc loads its length
      if (phase_next == PH_CRC && cur_phase != PH_CRC) begin
        skip_count_next = CRC_LEN;
      end

      if (cur_count != '1) begin
        byte_count_next = cur_count + 1'b1;
      end

      if (phase_next == PH_PAYLOAD) begin
        status_next = ST_LAST;
      end else if (stream_end) begin
        error_latched_next = ERR_TRUNC;
        phase_next = PH_ERROR;
        status_next = ST_ERROR;
        code_next = ERR_TRUNC;
      end
    end
  end

  // saturate the counter to the reported width
  assign count_wide = CMP_W'(byte_count_next);
  always_comb begin
    if (count_wide > CMP_W'({HDR_LEN_W{1'b1}})) begin
      length_next = '1;
    end else begin
      length_next = HDR_LEN_W'(count_wide);
    end
  end

  // parse state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIXED;
      fixed_index <= 4'd0;
      flag_bits <= 5'd0;
      skip_count <= 16'd0;
      length_low <= 8'd0;
      byte_count <= '0;
      error_latched <= ERR_NONE;
    end else if (accept) begin
      phase <= phase_next;
      fixed_index <= fixed_index_next;
      flag_bits <= flag_bits_next;
      skip_count <= skip_count_next;
      length_low <= length_low_next;
      byte_count <= byte_count_next;
      error_latched <= error_latched_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      error_code <= code_next;
      header_length <= length_next;
      payload_byte <= pay_next;
    end
  end

`ifndef NO_ASSERTIONS
  // error code present exactly on error items
  a_code_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ERROR |-> error_code != ERR_NONE)
    else $error("error item without error code");

  a_no_code_otherwise: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_ERROR |-> error_code == ERR_NONE)
    else $error("error code on a non-error item");

  // payload byte only carried by payload items
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_PAYLOAD |-> payload_byte == 8'd0)
    else $error("payload byte on a non-payload item");

  // input stalls only while a result is held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no held result");
`endif

endmodule
